@@ rtl/core/hkst_pkg.sv @@
// Shared types and constants for the held key slot table.
package hkst_pkg;

  localparam int unsigned KEY_W = 7;
  localparam int unsigned OUT_W = 5;

  // Command codes of an input beat.
  localparam logic CMD_ON  = 1'b0;
  localparam logic CMD_OFF = 1'b1;

  // Slot index reported when no slot holds the key (-1 in two's complement).
  localparam logic [OUT_W-1:0] SLOT_NONE = {OUT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } st_e;

  // Status from the scan unit to the top-level sequencer.
  typedef struct packed {
    logic done;   // last slot is being compared this cycle
    logic match;  // current slot equals the key
    logic found;  // some earlier slot matched the key
    logic empty;  // some earlier slot was empty
  } scan_res_t;

endpackage

@@ rtl/core/hkst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hkst_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/hkst_scan.sv @@
// Slot scan unit: walks the table one slot per cycle and keeps first match and first empty slot.
module hkst_scan #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IW    = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [hkst_pkg::KEY_W-1:0] key_i,
  input  logic [hkst_pkg::KEY_W-1:0] slot_val_i,
  output logic                     rd_en_o,
  output logic [IW-1:0]            rd_addr_o,
  output logic                     cmp_vld_o,
  output logic [IW-1:0]            cmp_idx_o,
  output hkst_pkg::scan_res_t      res_o,
  output logic [IW-1:0]            found_idx_o,
  output logic [IW-1:0]            empty_idx_o
);
  import hkst_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic          issue_q, issue_d;
  logic [IW-1:0] addr_q, addr_d;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic          found_q, found_d;
  logic [IW-1:0] found_idx_q, found_idx_d;
  logic          empty_q, empty_d;
  logic [IW-1:0] empty_idx_q, empty_idx_d;
  logic          match;
  logic          is_empty;

  assign match    = (slot_val_i == key_i);
  assign is_empty = (slot_val_i == '0);

  always_comb begin
    issue_d     = issue_q;
    addr_d      = addr_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    if (start_i) begin
      issue_d = 1'b1;
      addr_d  = '0;
      found_d = 1'b0;
      empty_d = 1'b0;
    end else begin
      if (issue_q) begin
        addr_d = addr_q + IW'(1);
        if (addr_q == LAST) begin
          issue_d = 1'b0;
        end
      end
      // Read data arrives in the cycle after its address, so compares use cmp_idx_q.
      if (cmp_vld_q && match && !found_q) begin
        found_d     = 1'b1;
        found_idx_d = cmp_idx_q;
      end
      if (cmp_vld_q && is_empty && !empty_q) begin
        empty_d     = 1'b1;
        empty_idx_d = cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= 1'b0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      found_q   <= 1'b0;
      empty_q   <= 1'b0;
    end else begin
      issue_q   <= issue_d;
      addr_q    <= addr_d;
      cmp_vld_q <= issue_q;
      cmp_idx_q <= addr_q;
      found_q   <= found_d;
      empty_q   <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_idx_q <= found_idx_d;
    empty_idx_q <= empty_idx_d;
  end

  assign rd_en_o     = issue_q;
  assign rd_addr_o   = addr_q;
  assign cmp_vld_o   = cmp_vld_q;
  assign cmp_idx_o   = cmp_idx_q;
  assign found_idx_o = found_idx_q;
  assign empty_idx_o = empty_idx_q;
  assign res_o.done  = cmp_vld_q && (cmp_idx_q == LAST);
  assign res_o.match = cmp_vld_q && match;
  assign res_o.found = found_q;
  assign res_o.empty = empty_q;

endmodule

@@ rtl/core/held_key_slot_table.sv @@
// Top level of the held key slot table: sequencer, slot valid bits, use count and result register.
//
// Input channel (in_valid_i / in_ready_o) carries one key event per beat: command_i
// (0 = key pressed, 1 = key released) and key_i. Output channel (out_valid_o /
// out_ready_i) returns one beat per event: slot_index_o (-1 if the key is not held),
// used_count_o and table_cleared_o.
// Each event scans the slot RAM one slot per cycle through a single compare unit.
// From acceptance to its result beat, an event goes through these steps: start the
// scan, read and compare every slot (read data is registered), and then write the
// RAM and load the result register. in_ready_o is high only while the sequencer
// is idle, so a new event is taken only after the previous one has made its
// final write.
// After reset all slots read as empty: per-slot valid bits are cleared at once and
// the used count is zero, so no clearing pass is needed.
// If the receiver stalls, the finished result waits in the output register; the
// next event may already be accepted and scanned, and it waits before its final
// write until the pending result beat has been taken.
module held_key_slot_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [hkst_pkg::KEY_W-1:0]      key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [hkst_pkg::OUT_W-1:0] slot_index_o,
  output logic [hkst_pkg::OUT_W-1:0]      used_count_o,
  output logic                            table_cleared_o
);
  import hkst_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  st_e               state_q, state_d;
  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [CW-1:0]     used_q, used_d;
  logic              out_valid_q;
  logic [OUT_W-1:0]  slot_index_q, slot_index_d;
  logic [OUT_W-1:0]  used_count_q;
  logic              cleared_q, cleared_d;

  logic              scan_start;
  logic              done_fire;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [KEY_W-1:0]  rdata;
  logic              cmp_vld;
  logic [IW-1:0]     cmp_idx;
  scan_res_t         scan_res;
  logic [IW-1:0]     found_idx;
  logic [IW-1:0]     empty_idx;
  logic [KEY_W-1:0]  slot_val;
  logic              we;
  logic [IW-1:0]     waddr;
  logic              key_nz;
  logic [IW-1:0]     pick;
  logic [IW+OUT_W-1:0] pick_ext;
  logic [CW+OUT_W-1:0] used_ext;

  hkst_ram #(
    .WIDTH(KEY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(key_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // A slot whose valid bit is low reads as empty whatever the RAM holds.
  assign slot_val = valid_q[cmp_idx] ? rdata : '0;

  hkst_scan #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .key_i      (key_q),
    .slot_val_i (slot_val),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .cmp_vld_o  (cmp_vld),
    .cmp_idx_o  (cmp_idx),
    .res_o      (scan_res),
    .found_idx_o(found_idx),
    .empty_idx_o(empty_idx)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    done_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SCAN: ;
      ST_DONE: done_fire = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // The scan starts in the cycle after acceptance, once the key is registered.
  logic start_q;
  assign scan_start = start_q;

  assign key_nz = (key_q != '0);

  // Table update and result.
  always_comb begin
    valid_d   = valid_q;
    used_d    = used_q;
    we        = 1'b0;
    waddr     = '0;
    cleared_d = 1'b0;
    // A release empties every matching slot as the scan passes it.
    if (state_q == ST_SCAN && cmp_vld && cmd_q == CMD_OFF && scan_res.match && key_nz) begin
      valid_d[cmp_idx] = 1'b0;
      used_d           = used_q - CW'(1);
    end
    if (done_fire && cmd_q == CMD_ON && !scan_res.found) begin
      we = 1'b1;
      if (scan_res.empty) begin
        waddr              = empty_idx;
        valid_d[empty_idx] = key_nz;
        used_d             = used_q + CW'(key_nz);
      end else begin
        // Full table: drop every key, then the new key takes slot zero.
        valid_d    = '0;
        valid_d[0] = key_nz;
        used_d     = CW'(key_nz);
        cleared_d  = 1'b1;
      end
    end
  end

  always_comb begin
    if (scan_res.found) begin
      pick = found_idx;
    end else if (scan_res.empty) begin
      pick = empty_idx;
    end else begin
      pick = '0;
    end
    pick_ext = {{OUT_W{1'b0}}, pick};
    used_ext = {{OUT_W{1'b0}}, used_d};
    if (cmd_q == CMD_OFF || !key_nz) begin
      slot_index_d = SLOT_NONE;
    end else begin
      slot_index_d = pick_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      valid_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_valid_i && in_ready_o;
      valid_q <= valid_d;
      used_q  <= used_d;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      key_q <= key_i;
    end
    if (done_fire) begin
      slot_index_q <= slot_index_d;
      used_count_q <= used_ext[OUT_W-1:0];
      cleared_q    <= cleared_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_index_o    = $signed(slot_index_q);
  assign used_count_o    = used_count_q;
  assign table_cleared_o = cleared_q;

`ifndef ASSERT_OFF
  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == used_q)
    else $error("used count disagrees with slot valid bits");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SLOTS)
    else $error("used count exceeds table size");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> state_q == ST_SCAN)
    else $error("scan finished outside the scan state");

  a_clear_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_cleared_o) |->
      (slot_index_q == '0 || slot_index_q == SLOT_NONE))
    else $error("cleared table reported a slot other than zero");

  a_start_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_SCAN && start_q)
    else $error("accepted beat did not start a scan");
`endif

endmodule
